### rtl/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, character codes and helpers for the NMEA sentence deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsd_pkg;

  // Sizing
  localparam int unsigned LINE_CAPACITY   = 160;
  localparam int unsigned MAX_FIELD_COUNT = 24;
  localparam int unsigned LineCntW        = $clog2(LINE_CAPACITY);
  localparam int unsigned FieldCntW       = $clog2(MAX_FIELD_COUNT + 1);

  // Character codes
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_UC_A   = 8'h41;
  localparam logic [7:0] CHR_UC_B   = 8'h42;
  localparam logic [7:0] CHR_UC_C   = 8'h43;
  localparam logic [7:0] CHR_UC_D   = 8'h44;
  localparam logic [7:0] CHR_UC_G   = 8'h47;
  localparam logic [7:0] CHR_UC_L   = 8'h4C;
  localparam logic [7:0] CHR_UC_M   = 8'h4D;
  localparam logic [7:0] CHR_UC_P   = 8'h50;
  localparam logic [7:0] CHR_UC_R   = 8'h52;
  localparam logic [7:0] CHR_UC_S   = 8'h53;
  localparam logic [7:0] CHR_UC_V   = 8'h56;

  typedef enum logic [2:0] {
    TALKER_GP      = 3'd0,
    TALKER_GL      = 3'd1,
    TALKER_GA      = 3'd2,
    TALKER_BEIDOU  = 3'd3,
    TALKER_UNKNOWN = 3'd4
  } talker_e;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_RMC   = 3'd1,
    KIND_GGA   = 3'd2,
    KIND_GSA   = 3'd3,
    KIND_GSV   = 3'd4
  } kind_e;

  typedef struct packed {
    logic        sentence_ok;
    logic        checksum_present;
    logic        checksum_match;
    talker_e     talker_slot;
    kind_e       sentence_kind;
    logic [4:0]  field_count;
    logic [7:0]  line_chars;
  } result_t;

  // Returns {valid, value} for an ASCII hex digit, either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

`default_nettype wire

### rtl/nsd_line_engine.sv
// ----------------------------------------------------------------------------
// nsd_line_engine
// Per-line state: framing, running XOR, checksum capture, field counting and
// head-field capture. Produces the verdict for a line-end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_line_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        byte_i,
  input  wire logic              step_i,   // consume byte_i this cycle
  output logic                   eol_hit_o, // byte_i closes an open line
  output nsd_pkg::result_t       result_o
);

  localparam int unsigned LCW = nsd_pkg::LineCntW;
  localparam int unsigned FCW = nsd_pkg::FieldCntW;
  localparam logic [LCW:0]   LineCap  = (LCW + 1)'(nsd_pkg::LINE_CAPACITY);
  localparam logic [FCW-1:0] FieldMax = FCW'(nsd_pkg::MAX_FIELD_COUNT);

  logic [LCW-1:0] line_cnt_q, line_cnt_d;
  logic [7:0]     xor_q, xor_d;
  logic           star_q, star_d;
  logic [1:0]     after_q, after_d;
  logic [7:0]     exp_q, exp_d;
  logic [1:0]     hexf_q, hexf_d;
  logic           head_done_q, head_done_d;
  logic [2:0]     head_len_q, head_len_d;
  logic [15:0]    talker_q, talker_d;
  logic [23:0]    tail_q, tail_d;
  logic [FCW-1:0] comma_cnt_q, comma_cnt_d;
  logic           last_comma_q, last_comma_d;

  logic           is_eol, line_open, is_comma, room;
  logic [4:0]     hex;
  logic           present, match, head_ok;
  logic [7:0]     tk_a, tk_b;
  nsd_pkg::talker_e talker;
  nsd_pkg::kind_e   kind;

  assign is_eol    = (byte_i == nsd_pkg::CHR_CR) || (byte_i == nsd_pkg::CHR_LF);
  assign line_open = (line_cnt_q != '0);
  assign is_comma  = (byte_i == nsd_pkg::CHR_COMMA);
  assign room      = (({1'b0, line_cnt_q} + (LCW + 1)'(1)) < LineCap);
  assign hex       = nsd_pkg::hex_digit(byte_i);
  assign eol_hit_o = is_eol && line_open;

  // Verdict from the state before the line-end byte
  assign present = star_q && (after_q >= 2'd2);
  assign head_ok = (head_len_q >= 3'd5);
  always_comb begin
    if (!present)        match = 1'b1;
    else if (!hexf_q[0]) match = 1'b0;
    else                 match = (xor_q == exp_q);
  end

  assign tk_a = talker_q[15:8];
  assign tk_b = talker_q[7:0];

  always_comb begin
    talker = nsd_pkg::TALKER_UNKNOWN;
    if (tk_a == nsd_pkg::CHR_UC_G && tk_b == nsd_pkg::CHR_UC_P) begin
      talker = nsd_pkg::TALKER_GP;
    end else if (tk_a == nsd_pkg::CHR_UC_G && tk_b == nsd_pkg::CHR_UC_L) begin
      talker = nsd_pkg::TALKER_GL;
    end else if (tk_a == nsd_pkg::CHR_UC_G && tk_b == nsd_pkg::CHR_UC_A) begin
      talker = nsd_pkg::TALKER_GA;
    end else if ((tk_a == nsd_pkg::CHR_UC_G && tk_b == nsd_pkg::CHR_UC_B) ||
                 (tk_a == nsd_pkg::CHR_UC_B && tk_b == nsd_pkg::CHR_UC_D)) begin
      talker = nsd_pkg::TALKER_BEIDOU;
    end
    if (!head_ok) talker = nsd_pkg::TALKER_UNKNOWN;
  end

  always_comb begin
    kind = nsd_pkg::KIND_OTHER;
    if (tail_q == {nsd_pkg::CHR_UC_R, nsd_pkg::CHR_UC_M, nsd_pkg::CHR_UC_C}) begin
      kind = nsd_pkg::KIND_RMC;
    end else if (tail_q == {nsd_pkg::CHR_UC_G, nsd_pkg::CHR_UC_G, nsd_pkg::CHR_UC_A}) begin
      kind = nsd_pkg::KIND_GGA;
    end else if (tail_q == {nsd_pkg::CHR_UC_G, nsd_pkg::CHR_UC_S, nsd_pkg::CHR_UC_A}) begin
      kind = nsd_pkg::KIND_GSA;
    end else if (tail_q == {nsd_pkg::CHR_UC_G, nsd_pkg::CHR_UC_S, nsd_pkg::CHR_UC_V}) begin
      kind = nsd_pkg::KIND_GSV;
    end
    if (!head_ok) kind = nsd_pkg::KIND_OTHER;
  end

  always_comb begin
    result_o.sentence_ok      = match && head_ok;
    result_o.checksum_present = present;
    result_o.checksum_match   = match;
    result_o.talker_slot      = talker;
    result_o.sentence_kind    = kind;
    result_o.field_count      = 5'(comma_cnt_q);
    result_o.line_chars       = 8'(line_cnt_q);
  end

  // Next state
  always_comb begin
    line_cnt_d   = line_cnt_q;
    xor_d        = xor_q;
    star_d       = star_q;
    after_d      = after_q;
    exp_d        = exp_q;
    hexf_d       = hexf_q;
    head_done_d  = head_done_q;
    head_len_d   = head_len_q;
    talker_d     = talker_q;
    tail_d       = tail_q;
    comma_cnt_d  = comma_cnt_q;
    last_comma_d = last_comma_q;

    if (is_eol) begin
      line_cnt_d = '0;
    end else if (!line_open) begin
      if (byte_i == nsd_pkg::CHR_DOLLAR) begin
        line_cnt_d   = LCW'(1);
        xor_d        = '0;
        star_d       = 1'b0;
        after_d      = '0;
        exp_d        = '0;
        hexf_d       = '0;
        head_done_d  = 1'b0;
        head_len_d   = '0;
        talker_d     = '0;
        tail_d       = '0;
        comma_cnt_d  = '0;
        last_comma_d = 1'b1;
      end
    end else if (!room) begin
      line_cnt_d = '0;  // overlong line dropped
    end else begin
      line_cnt_d = line_cnt_q + LCW'(1);
      if (star_q) begin
        // checksum text: first two characters only
        if (after_q < 2'd2 && hex[4]) begin
          if (after_q == 2'd0) begin
            hexf_d[0] = 1'b1;
            exp_d     = {4'h0, hex[3:0]};
          end else begin
            hexf_d[1] = 1'b1;
            exp_d     = {exp_q[3:0], hex[3:0]};
          end
        end
        if (after_q != 2'd3) after_d = after_q + 2'd1;
      end else if (byte_i == nsd_pkg::CHR_STAR) begin
        star_d      = 1'b1;
        head_done_d = 1'b1;
      end else begin
        xor_d = xor_q ^ byte_i;
        if (last_comma_q && comma_cnt_q < FieldMax) comma_cnt_d = comma_cnt_q + FCW'(1);
        last_comma_d = is_comma;
        if (!head_done_q) begin
          if (is_comma) begin
            head_done_d = 1'b1;
          end else begin
            if (head_len_q == 3'd0)      talker_d = {byte_i, 8'h00};
            else if (head_len_q == 3'd1) talker_d = {talker_q[15:8], byte_i};
            if (head_len_q != 3'd7) head_len_d = head_len_q + 3'd1;
            tail_d = {tail_q[15:0], byte_i};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q   <= '0;
      xor_q        <= '0;
      star_q       <= 1'b0;
      after_q      <= '0;
      exp_q        <= '0;
      hexf_q       <= '0;
      head_done_q  <= 1'b0;
      head_len_q   <= '0;
      talker_q     <= '0;
      tail_q       <= '0;
      comma_cnt_q  <= '0;
      last_comma_q <= 1'b0;
    end else if (step_i) begin
      line_cnt_q   <= line_cnt_d;
      xor_q        <= xor_d;
      star_q       <= star_d;
      after_q      <= after_d;
      exp_q        <= exp_d;
      hexf_q       <= hexf_d;
      head_done_q  <= head_done_d;
      head_len_q   <= head_len_d;
      talker_q     <= talker_d;
      tail_q       <= tail_d;
      comma_cnt_q  <= comma_cnt_d;
      last_comma_q <= last_comma_d;
    end
  end

endmodule

`default_nettype wire

### rtl/nsd_result_reg.sv
// ----------------------------------------------------------------------------
// nsd_result_reg
// Output register for one verdict with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_result_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire nsd_pkg::result_t data_i,
  output logic                  free_o,   // may load this cycle
  output logic                  valid_o,
  input  wire logic             ready_i,
  output nsd_pkg::result_t      data_o
);

  logic             vld_q, vld_d;
  nsd_pkg::result_t data_q;

  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i)       vld_d = 1'b1;
    else if (ready_i) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/nmea_sentence_deframer.sv
// ----------------------------------------------------------------------------
// nmea_sentence_deframer
// NMEA 0183 line deframer with checksum check and sentence classification.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns one verdict transaction
// for every line closed by CR or LF. A line opens at '$'; bytes outside a line
// are ignored, and a line that would reach LINE_CAPACITY characters is dropped
// silently. Throughput is one byte per clock while nothing stalls: a byte
// sits in the input register while the line engine updates its state, and a
// verdict is loaded into the output register when its line-end byte is
// consumed from the input register, as long as the output register is free.
// The only thing that holds the input side back is a line-end byte meeting a
// verdict the consumer has not yet taken; other bytes keep flowing even then.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte input
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  // verdict output
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            sentence_ok_o,
  output logic            checksum_present_o,
  output logic            checksum_match_o,
  output logic [2:0]      talker_slot_o,
  output logic [2:0]      sentence_kind_o,
  output logic [4:0]      field_count_o,
  output logic [7:0]      line_chars_o
);

  // Input register
  logic       byte_vld_q, byte_vld_d;
  logic [7:0] byte_q;

  logic             eol_hit;   // held byte closes a line and yields a verdict
  logic             out_free;  // output register can take a verdict now
  logic             step;      // held byte is consumed this cycle
  nsd_pkg::result_t verdict;
  nsd_pkg::result_t out_data;

  // A line-end byte waits only for space in the output register.
  assign step       = byte_vld_q && (!eol_hit || out_free);
  assign in_ready_o = !byte_vld_q || step;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (in_valid_i && in_ready_o) byte_vld_d = 1'b1;
    else if (step)                byte_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  // Framing, XOR, checksum capture, field count, classification
  nsd_line_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_q),
    .step_i    (step),
    .eol_hit_o (eol_hit),
    .result_o  (verdict)
  );

  // Verdict register; decouples the consumer from the byte stream
  nsd_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && eol_hit),
    .data_i  (verdict),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign sentence_ok_o      = out_data.sentence_ok;
  assign checksum_present_o = out_data.checksum_present;
  assign checksum_match_o   = out_data.checksum_match;
  assign talker_slot_o      = 3'(out_data.talker_slot);
  assign sentence_kind_o    = 3'(out_data.sentence_kind);
  assign field_count_o      = out_data.field_count;
  assign line_chars_o       = out_data.line_chars;

endmodule

`default_nettype wire

### rtl/nsd_port_monitor.sv
// ----------------------------------------------------------------------------
// nsd_port_monitor
// Port-level assertions for the NMEA sentence deframer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nsd_port_monitor (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       sentence_ok_o,
  input wire logic       checksum_present_o,
  input wire logic       checksum_match_o,
  input wire logic [2:0] talker_slot_o,
  input wire logic [2:0] sentence_kind_o,
  input wire logic [4:0] field_count_o,
  input wire logic [7:0] line_chars_o
);

  // A waiting byte stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("byte changed or withdrawn while waiting");

  // A stalled verdict stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("verdict dropped while stalled");

  // A stalled verdict keeps its contents
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(sentence_ok_o) && $stable(checksum_match_o) &&
      $stable(checksum_present_o) && $stable(line_chars_o) &&
      $stable(field_count_o) && $stable(talker_slot_o) &&
      $stable(sentence_kind_o))
    else $error("verdict changed while stalled");

  // A good sentence has a matching checksum and at least "$" plus five chars
  a_ok_implies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_ok_o |-> checksum_match_o && (line_chars_o >= 8'd6))
    else $error("sentence_ok without its preconditions");

  // No checksum text means no mismatch; line length is never zero
  a_absent_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !checksum_present_o |-> checksum_match_o && (line_chars_o != 8'd0))
    else $error("mismatch reported without checksum text");

endmodule

bind nmea_sentence_deframer nsd_port_monitor u_port_monitor (.*);

`default_nettype wire
